FILE: hw/rtl/sgr_pkg.sv
// Package for the scatter-gather range resolver.
// Holds word types, command and status codes, and width constants.
// No dependencies.
`default_nettype none

package sgr_pkg;

	localparam int unsigned DEFAULT_MAX_ENTRIES = 256;

	localparam int unsigned LEN_W   = 48;
	localparam int unsigned BASE_W  = 56;
	localparam int unsigned IDX_W   = 9;
	localparam int unsigned STAT_W  = 2;

	// command codes
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_ENTRY = 1'b1;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_PAST     = 2'd1;
	localparam logic [STAT_W-1:0] ST_SHORT    = 2'd2;
	localparam logic [STAT_W-1:0] ST_TOO_MANY = 2'd3;

	typedef struct packed {
		logic              cmd;
		logic [LEN_W-1:0]  offset;
		logic [LEN_W-1:0]  length;
		logic [LEN_W-1:0]  entry_len;
		logic              last;
	} sgr_in_t;

	typedef struct packed {
		logic [IDX_W-1:0]  start_index;
		logic [BASE_W-1:0] start_base;
		logic [IDX_W-1:0]  segments;
		logic [STAT_W-1:0] status;
	} sgr_out_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sgr_walk.sv
// List walk state and its combinational update for the range resolver.
// Advances the offset search and coverage count by one word per step.
// Depends on sgr_pkg.
`default_nettype none

module sgr_walk #(
	parameter int unsigned MAX_ENTRIES = sgr_pkg::DEFAULT_MAX_ENTRIES
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire sgr_pkg::sgr_in_t item,
	output logic                 res_valid,
	output sgr_pkg::sgr_out_t    res
);

	localparam int unsigned IW = $clog2(MAX_ENTRIES + 1);

	localparam logic PH_SEEK  = 1'b0;
	localparam logic PH_COUNT = 1'b1;

	logic                        phase_q;
	logic [sgr_pkg::LEN_W-1:0]   held_offset_q;
	logic [sgr_pkg::LEN_W-1:0]   held_length_q;
	logic [sgr_pkg::LEN_W-1:0]   off_left_q;
	logic [sgr_pkg::LEN_W-1:0]   len_left_q;
	logic [sgr_pkg::BASE_W-1:0]  base_sum_q;
	logic [IW-1:0]               entry_index_q;
	logic [IW-1:0]               seg_count_q;
	logic [IW-1:0]               start_at_q;
	logic                        overflow_q;

	logic                        phase_n;
	logic [sgr_pkg::LEN_W-1:0]   off_left_n;
	logic [sgr_pkg::LEN_W-1:0]   len_left_n;
	logic [sgr_pkg::BASE_W-1:0]  base_sum_n;
	logic [IW-1:0]               entry_index_n;
	logic [IW-1:0]               seg_count_n;
	logic [IW-1:0]               start_at_n;
	logic                        overflow_n;

	logic                        full;
	logic                        seeking;
	logic                        hit;
	logic                        counting;
	logic [sgr_pkg::LEN_W-1:0]   avail;
	logic [sgr_pkg::LEN_W-1:0]   take;

	assign full     = entry_index_q >= IW'(MAX_ENTRIES);
	assign seeking  = phase_q == PH_SEEK;
	assign hit      = item.entry_len >= off_left_q;
	// bytes of this entry past the offset; whole entry once the start is found
	assign avail    = seeking ? item.entry_len - off_left_q : item.entry_len;
	assign take     = (avail > len_left_q) ? len_left_q : avail;

	always_comb begin
		phase_n       = phase_q;
		off_left_n    = off_left_q;
		len_left_n    = len_left_q;
		base_sum_n    = base_sum_q;
		entry_index_n = entry_index_q;
		seg_count_n   = seg_count_q;
		start_at_n    = start_at_q;
		overflow_n    = overflow_q;
		counting      = 1'b0;
		if (full) begin
			overflow_n = 1'b1;
		end else begin
			if (seeking) begin
				if (hit) begin
					phase_n    = PH_COUNT;
					off_left_n = '0;
					start_at_n = entry_index_q;
				end else begin
					off_left_n = off_left_q - item.entry_len;
					base_sum_n = base_sum_q + sgr_pkg::BASE_W'(item.entry_len);
				end
			end
			counting = (phase_n == PH_COUNT) && (len_left_q != '0);
			if (counting) begin
				len_left_n  = len_left_q - take;
				seg_count_n = seg_count_q + IW'(1);
			end
			entry_index_n = entry_index_q + IW'(1);
		end
	end

	assign res_valid = (item.cmd == sgr_pkg::CMD_ENTRY) && item.last;

	always_comb begin
		res = '0;
		if (overflow_n) begin
			res.status = sgr_pkg::ST_TOO_MANY;
		end else if (phase_n == PH_SEEK) begin
			res.status      = sgr_pkg::ST_PAST;
			res.start_index = sgr_pkg::IDX_W'(entry_index_n);
			res.start_base  = base_sum_n;
		end else begin
			res.status      = (len_left_n != '0) ? sgr_pkg::ST_SHORT : sgr_pkg::ST_OK;
			res.start_index = sgr_pkg::IDX_W'(start_at_n);
			res.start_base  = base_sum_n;
			res.segments    = sgr_pkg::IDX_W'(seg_count_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_SEEK;
			held_offset_q <= '0;
			held_length_q <= '0;
			off_left_q    <= '0;
			len_left_q    <= '0;
			base_sum_q    <= '0;
			entry_index_q <= '0;
			seg_count_q   <= '0;
			start_at_q    <= '0;
			overflow_q    <= 1'b0;
		end else if (step) begin
			if (item.cmd == sgr_pkg::CMD_START || item.last) begin
				// clear list progress; a start also loads a new range
				phase_q       <= PH_SEEK;
				base_sum_q    <= '0;
				entry_index_q <= '0;
				seg_count_q   <= '0;
				start_at_q    <= '0;
				overflow_q    <= 1'b0;
				if (item.cmd == sgr_pkg::CMD_START) begin
					held_offset_q <= item.offset;
					held_length_q <= item.length;
					off_left_q    <= item.offset;
					len_left_q    <= item.length;
				end else begin
					off_left_q <= held_offset_q;
					len_left_q <= held_length_q;
				end
			end else begin
				phase_q       <= phase_n;
				off_left_q    <= off_left_n;
				len_left_q    <= len_left_n;
				base_sum_q    <= base_sum_n;
				entry_index_q <= entry_index_n;
				seg_count_q   <= seg_count_n;
				start_at_q    <= start_at_n;
				overflow_q    <= overflow_n;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/scatter_gather_range_resolver.sv
// Scatter-gather range resolver: the result word of the last list word shows on out_data
// once that word has passed the input register and then the result register.
// Throughput: one word per cycle unless a last word waits on a full result register; the
// walk state updates combinationally through a 48-bit compare, subtract and clamp per entry.
// Reset (arst_n low) clears the walk state, the held offset and length, and both
// valid flags at once.
`default_nettype none

module scatter_gather_range_resolver #(
	parameter int unsigned MAX_ENTRIES = sgr_pkg::DEFAULT_MAX_ENTRIES
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire sgr_pkg::sgr_in_t in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output sgr_pkg::sgr_out_t     out_data
);

	logic              s1_valid_q;
	sgr_pkg::sgr_in_t  item_s1;
	logic              s1_go;
	logic              res_valid;
	sgr_pkg::sgr_out_t res;
	logic              out_valid_q;
	sgr_pkg::sgr_out_t out_q;

	sgr_walk #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (s1_go),
		.item     (item_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	// hold a result-producing word while the result register stays full
	assign s1_go    = s1_valid_q && (!res_valid || !out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_stall_only_when_full : assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (s1_valid_q && out_valid_q && !out_ready))
		else $error("input stalled without a full result register");

	a_result_lands : assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && res_valid) |=> out_valid_q)
		else $error("last word stepped but no result registered");

	a_too_many_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == sgr_pkg::ST_TOO_MANY) |->
		(out_q.start_index == '0 && out_q.start_base == '0 && out_q.segments == '0))
		else $error("too-many-entries result carries nonzero fields");

	a_past_no_segments : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == sgr_pkg::ST_PAST) |-> (out_q.segments == '0))
		else $error("offset-past-list result reports segments");

endmodule

`default_nettype wire

FILE: dv/sgr_range_scoreboard_pkg.sv
// Scoreboard for the scatter-gather range resolver: walks each list the way
// the block does and checks every result word against the oldest prediction.
// Depends on sgr_pkg for the word types, command and status codes.
package sgr_range_scoreboard_pkg;

	import sgr_pkg::*;

	class sgr_range_scoreboard;

		// list walk state, mirrors the block
		logic [LEN_W-1:0]  held_offset;
		logic [LEN_W-1:0]  held_length;
		logic [LEN_W-1:0]  consumed;
		logic [LEN_W-1:0]  covered;
		logic [BASE_W-1:0] base_sum;
		int unsigned       entry_index;
		int unsigned       seg_count;
		int unsigned       start_at;
		bit                counting;
		bit                overflow;
		int unsigned       max_entries;

		sgr_out_t          resolved_q[$];
		int unsigned       errors;
		int unsigned       checked;
		int unsigned       status_seen[4];

		function new(int unsigned max_entries);
			this.max_entries = max_entries;
			held_offset = '0;
			held_length = '0;
			errors = 0;
			checked = 0;
			foreach (status_seen[i])
				status_seen[i] = 0;
			clear_walk();
		endfunction

		function void clear_walk();
			consumed = '0;
			covered = '0;
			base_sum = '0;
			entry_index = 0;
			seg_count = 0;
			start_at = 0;
			counting = 1'b0;
			overflow = 1'b0;
		endfunction

		function int unsigned pending();
			return resolved_q.size();
		endfunction

		// Advance the walk by one accepted word; queue a result on a last entry.
		function void note_word(sgr_in_t w);
			logic [LEN_W-1:0] skip;
			logic [LEN_W-1:0] bytes;
			logic [LEN_W-1:0] remain;
			sgr_out_t res;
			if (w.cmd == CMD_START) begin
				held_offset = w.offset;
				held_length = w.length;
				clear_walk();
				return;
			end
			if (entry_index >= max_entries) begin
				overflow = 1'b1;
			end else begin
				skip = '0;
				if (!counting) begin
					skip = held_offset - consumed;
					if (skip > w.entry_len)
						skip = w.entry_len;
					consumed = consumed + skip;
					if (consumed >= held_offset) begin
						counting = 1'b1;
						start_at = entry_index;
					end else begin
						base_sum = base_sum + BASE_W'(w.entry_len);
					end
				end
				// entries past full coverage are not segments
				if (counting && covered < held_length) begin
					bytes = w.entry_len - skip;
					remain = held_length - covered;
					if (bytes > remain)
						bytes = remain;
					seg_count++;
					covered = covered + bytes;
				end
				entry_index++;
			end
			if (!w.last)
				return;
			if (overflow) begin
				res = '0;
				res.status = ST_TOO_MANY;
			end else if (!counting) begin
				res.start_index = entry_index[IDX_W-1:0];
				res.start_base = base_sum;
				res.segments = '0;
				res.status = ST_PAST;
			end else begin
				res.start_index = start_at[IDX_W-1:0];
				res.start_base = base_sum;
				res.segments = seg_count[IDX_W-1:0];
				res.status = (covered < held_length) ? ST_SHORT : ST_OK;
			end
			resolved_q.push_back(res);
			clear_walk();
		endfunction

		function void check_result(sgr_out_t got);
			sgr_out_t want;
			if (resolved_q.size() == 0) begin
				errors++;
				$error("result word with nothing expected: %h", got);
				return;
			end
			want = resolved_q.pop_front();
			checked++;
			status_seen[want.status]++;
			if (got.start_index !== want.start_index) begin
				errors++;
				$error("start_index: expected %0d, got %0d", want.start_index, got.start_index);
			end
			if (got.start_base !== want.start_base) begin
				errors++;
				$error("start_base: expected %0d, got %0d", want.start_base, got.start_base);
			end
			if (got.segments !== want.segments) begin
				errors++;
				$error("segments: expected %0d, got %0d", want.segments, got.segments);
			end
			if (got.status !== want.status) begin
				errors++;
				$error("status: expected %0d, got %0d", want.status, got.status);
			end
		endfunction

	endclass

endpackage

FILE: dv/scatter_gather_range_resolver_test.sv
// Testbench top for scatter_gather_range_resolver: directed lists, then random
// lists with random idling on both sides. Depends on sgr_pkg and
// sgr_range_scoreboard_pkg.
module scatter_gather_range_resolver_test;

	import sgr_pkg::*;
	import sgr_range_scoreboard_pkg::*;

	localparam int unsigned MAX_ENTRIES = DEFAULT_MAX_ENTRIES;
	localparam int unsigned ITEMS       = 1950;
	localparam int unsigned QUIET_TAIL  = 200;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	sgr_in_t  in_data;
	logic     out_valid;
	logic     out_ready;
	sgr_out_t out_data;

	sgr_range_scoreboard board;
	int unsigned words_sent = 0;
	int unsigned cycles = 0;
	bit          gaps_on = 1'b1;
	bit          quiet = 1'b0;
	logic [LEN_W-1:0] list_lens [0:511];

	scatter_gather_range_resolver #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && board != null && out_valid && out_ready)
			board.check_result(out_data);
	end

	// result side backpressure
	initial begin : sink_pace
		int unsigned stall_left;
		bit calm;
		stall_left = 0;
		calm = 1'b0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 99) == 0)
				calm = !calm;
			if (stall_left != 0 && !quiet) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 11);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic logic [LEN_W-1:0] rand48();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[LEN_W-1:0];
	endfunction

	function automatic sgr_in_t start_word(logic [LEN_W-1:0] off, logic [LEN_W-1:0] len);
		sgr_in_t w;
		w.cmd = CMD_START;
		w.offset = off;
		w.length = len;
		w.entry_len = rand48();
		w.last = 1'($urandom_range(0, 1));
		return w;
	endfunction

	function automatic sgr_in_t entry_word(logic [LEN_W-1:0] len, logic last);
		sgr_in_t w;
		w.cmd = CMD_ENTRY;
		w.offset = rand48();
		w.length = rand48();
		w.entry_len = len;
		w.last = last;
		return w;
	endfunction

	function automatic logic [LEN_W-1:0] pick_len(int unsigned mode);
		case (mode)
			0, 1, 2, 3, 4, 5:
				return ($urandom_range(0, 4) == 0) ? '0 : LEN_W'($urandom_range(1, 40));
			6, 7:
				return $urandom_range(0, 1) ? rand48() : LEN_W'($urandom_range(0, 40));
			8:
				return LEN_MAX - LEN_W'($urandom_range(0, 3));
			default:
				return rand48() >> $urandom_range(0, 47);
		endcase
	endfunction

	function automatic logic [63:0] sum_to(int unsigned k);
		logic [63:0] s;
		s = 0;
		for (int unsigned i = 0; i < k; i++)
			s += list_lens[i];
		return s;
	endfunction

	task automatic send_word(input sgr_in_t w);
		int unsigned gap;
		in_valid <= 1'b1;
		in_data <= w;
		do
			@(posedge clk);
		while (!in_ready);
		board.note_word(w);
		words_sent++;
		@(negedge clk);
		if (!quiet && gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// One list of n entries; offset and length aimed at entry ends and edges.
	task automatic run_list(input int unsigned n, input bit with_start, input bit close_list);
		int unsigned mode;
		int unsigned k;
		logic [63:0] total;
		logic [63:0] b;
		logic [63:0] off;
		logic [63:0] len;
		mode = $urandom_range(0, 9);
		total = 0;
		for (int unsigned i = 0; i < n; i++) begin
			list_lens[i] = pick_len(mode);
			total += list_lens[i];
		end
		if (with_start) begin
			k = $urandom_range(0, n);
			b = sum_to(k);
			case ($urandom_range(0, 9))
				0, 1, 2: off = b;
				3:       off = (b != 0 && $urandom_range(0, 1)) ? b - 1 : b + 1;
				4, 5, 6: off = {$urandom, $urandom} % (total + 1);
				7:       off = total + 64'($urandom_range(1, 50));
				8:       off = rand48();
				default: off = 0;
			endcase
			off = off & 64'(LEN_MAX);
			k = $urandom_range(0, n);
			b = sum_to(k);
			case ($urandom_range(0, 9))
				0:       len = 0;
				1, 2:    len = 64'($urandom_range(1, 60));
				3, 4, 5: len = (b > off) ? b - off : ((total > off) ? total - off : 0);
				6:       len = ((total > off) ? total - off : 0) + 1;
				7:       len = (total > off) ? {$urandom, $urandom} % (total - off + 1) : 0;
				8:       len = rand48();
				default: len = LEN_MAX;
			endcase
			send_word(start_word(off[LEN_W-1:0], len[LEN_W-1:0]));
		end
		for (int unsigned i = 0; i < n; i++)
			send_word(entry_word(list_lens[i], close_list && i == n - 1));
	endtask

	task automatic directed_cases();
		// entries with no start use the reset offset and length
		send_word(entry_word(48'd5, 1'b1));
		// offset lands on the end of the second entry
		send_word(start_word(48'd10, 48'd20));
		send_word(entry_word(48'd4, 1'b0));
		send_word(entry_word(48'd6, 1'b0));
		send_word(entry_word(48'd30, 1'b1));
		// offset beyond the list
		send_word(start_word(48'd100, 48'd5));
		send_word(entry_word(48'd10, 1'b0));
		send_word(entry_word(48'd20, 1'b1));
		// list ends before the range is covered
		send_word(start_word(48'd0, 48'd1000));
		send_word(entry_word(48'd10, 1'b0));
		send_word(entry_word(48'd0, 1'b0));
		send_word(entry_word(48'd20, 1'b1));
		// restart in the middle of a list
		send_word(start_word(48'd3, 48'd3));
		send_word(entry_word(48'd2, 1'b0));
		send_word(start_word(48'd0, 48'd0));
		send_word(entry_word(48'd0, 1'b1));
		send_word(start_word(LEN_MAX, LEN_MAX));
		send_word(entry_word(LEN_MAX, 1'b1));
		// zero length
		send_word(start_word(48'd5, 48'd0));
		send_word(entry_word(48'd5, 1'b1));
		// range covered before the last entry
		send_word(start_word(48'd2, 48'd4));
		send_word(entry_word(48'd8, 1'b0));
		send_word(entry_word(48'd8, 1'b1));
	endtask

	initial begin : stimulus
		int unsigned list_no;
		int unsigned n;
		sgr_in_t noise;
		board = new(MAX_ENTRIES);
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed_cases();

		list_no = 0;
		while (words_sent < ITEMS) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			if (words_sent >= ITEMS - QUIET_TAIL)
				quiet = 1'b1;
			list_no++;
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
			// full list, one entry past MAX_ENTRIES, and longer ones
			if (list_no == 20) begin
				run_list(MAX_ENTRIES, 1'b1, 1'b1);
			end else if (list_no == 60) begin
				run_list(MAX_ENTRIES + 1, 1'b1, 1'b1);
			end else if (list_no == 100) begin
				run_list($urandom_range(MAX_ENTRIES + 2, MAX_ENTRIES + 44), 1'b1, 1'b1);
			end else begin
				case ($urandom_range(0, 19))
					0: begin
						noise.cmd = 1'($urandom_range(0, 1));
						noise.offset = rand48();
						noise.length = rand48();
						noise.entry_len = rand48();
						noise.last = 1'($urandom_range(0, 1));
						send_word(noise);
					end
					1:       run_list(n, 1'b0, 1'b1);
					2:       run_list(n, 1'b1, 1'b0);
					default: run_list(n, 1'b1, 1'b1);
				endcase
			end
		end
		in_valid <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d words sent over %0d lists, %0d results checked", words_sent, list_no,
			board.checked);
		$display("status mix: ok %0d, past end %0d, too short %0d, too many %0d",
			board.status_seen[ST_OK], board.status_seen[ST_PAST],
			board.status_seen[ST_SHORT], board.status_seen[ST_TOO_MANY]);
		if (board.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
